/* rtl/gpsh_pkg.sv */
// Shared types, constants and helpers for the gait phase and swing height unit.
// No dependencies; imported by every module of the block.
package gpsh_pkg;

	localparam int NUM_LEGS       = 4;
	localparam int PHASE_BITS_DEF = 16;
	localparam int TIME_W         = 40;
	localparam int PER_W          = 24;

	localparam logic [24:0] ONE_Q24 = 25'h100_0000;

	// taylor coefficients of sin(x*pi/2) in Q24
	localparam logic [25:0] SC1 = 26'd26353589;
	localparam logic [25:0] SC3 = 26'd10837479;
	localparam logic [25:0] SC5 = 26'd1337020;
	localparam logic [25:0] SC7 = 26'd78547;
	localparam logic [25:0] SC9 = 26'd2692;

	localparam logic [31:0] PERIOD_RST = 32'd500000;
	localparam logic [31:0] SWING_RST  = 32'd50000;

	typedef enum logic [1:0] {
		REQ_CLEAR   = 2'd0,
		REQ_ADVANCE = 2'd1,
		REQ_QUERY   = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		REG_PERIOD = 3'd0,
		REG_SWING  = 3'd1,
		REG_OFF0   = 3'd2,
		REG_OFF1   = 3'd3,
		REG_OFF2   = 3'd4,
		REG_OFF3   = 3'd5
	} reg_idx_t;

	// lane status seen by the top level and the merge stage
	typedef struct packed {
		logic busy;
		logic done;
	} lane_stat_t;

	// Q24 quarter sine to Q1.14: round half up, cap at one, apply sign
	function automatic logic [15:0] q14_finish(logic [27:0] r, logic neg);
		logic [27:0] t;
		logic [17:0] m;
		logic [15:0] c;
		t = r + 28'd512;
		m = t[27:10];
		c = (m > 18'd16384) ? 16'd16384 : m[15:0];
		return neg ? 16'(-c) : c;
	endfunction

endpackage

/* rtl/gpsh_lane.sv */
// One leg lane: phase by bit-serial remainder and division, then sine, cosine
// and swing height through one shared multiplier. Depends on gpsh_pkg.
module gpsh_lane import gpsh_pkg::*; #(
	parameter int PhaseBits = PHASE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    take,
	input  logic [TIME_W-1:0]       time_us,
	input  logic [PER_W-1:0]        period_us,
	input  logic [15:0]             swing_height_um,
	input  logic signed [23:0]      offset_us,
	input  logic                    use_extra,
	input  logic [15:0]             extra_phase,
	output lane_stat_t              stat,
	output logic [15:0]             height,
	output logic signed [15:0]      cosine,
	output logic signed [15:0]      sine
);

	localparam int FracShift = 26 - PhaseBits;
	localparam logic [PhaseBits-1:0] Quarter = {2'b01, {(PhaseBits-2){1'b0}}};
	localparam logic [PhaseBits-1:0] Half    = {2'b10, {(PhaseBits-2){1'b0}}};
	localparam logic [5:0] ModLast = 6'd40;
	localparam logic [5:0] DivLast = 6'(PhaseBits - 1);

	// polynomial sequencer steps
	localparam logic [5:0] S_SIN_SQ   = 6'd0;
	localparam logic [5:0] S_SIN_C7   = 6'd1;
	localparam logic [5:0] S_SIN_C5   = 6'd2;
	localparam logic [5:0] S_SIN_C3   = 6'd3;
	localparam logic [5:0] S_SIN_C1   = 6'd4;
	localparam logic [5:0] S_SIN_END  = 6'd5;
	localparam logic [5:0] S_COS_SQ   = 6'd6;
	localparam logic [5:0] S_COS_C7   = 6'd7;
	localparam logic [5:0] S_COS_C5   = 6'd8;
	localparam logic [5:0] S_COS_C3   = 6'd9;
	localparam logic [5:0] S_COS_C1   = 6'd10;
	localparam logic [5:0] S_COS_END  = 6'd11;
	localparam logic [5:0] S_HGT_SQ   = 6'd12;
	localparam logic [5:0] S_HGT_EASE = 6'd13;
	localparam logic [5:0] S_HGT_END  = 6'd14;

	typedef enum logic [2:0] {ST_IDLE, ST_MOD, ST_DIV, ST_POLY, ST_DONE} state_t;

	state_t                 state_q;
	logic [5:0]             cnt_q;
	logic [40:0]            mag_q;
	logic                   neg_q;
	logic [PER_W-1:0]       per_q;
	logic [24:0]            rem_q;
	logic [PhaseBits-1:0]   quo_q;
	logic [24:0]            x2_q;
	logic [25:0]            acc_q;
	logic [15:0]            sin_q;
	logic [15:0]            cos_q;
	logic [15:0]            hgt_q;

	// start values: time sum and its magnitude
	logic signed [41:0]     tsum;
	logic [40:0]            tmag;
	logic [PER_W-1:0]       per_eff;
	assign tsum    = $signed({2'b00, time_us}) + 42'(offset_us);
	assign tmag    = tsum[41] ? 41'(-tsum) : tsum[40:0];
	assign per_eff = (period_us == '0) ? PER_W'(1) : period_us;

	// restoring remainder and division steps
	logic [24:0] per_x, rem_sh, rem_nx, rem_fix, rem_dv, rem_dnx;
	logic        ge_m, ge_d;
	assign per_x   = {1'b0, per_q};
	assign rem_sh  = {rem_q[23:0], mag_q[40]};
	assign ge_m    = rem_sh >= per_x;
	assign rem_nx  = ge_m ? rem_sh - per_x : rem_sh;
	assign rem_fix = (neg_q && rem_nx != '0) ? per_x - rem_nx : rem_nx;
	assign rem_dv  = {rem_q[23:0], 1'b0};
	assign ge_d    = rem_dv >= per_x;
	assign rem_dnx = ge_d ? rem_dv - per_x : rem_dv;

	// quarter-turn fractions for sine, cosine and height
	logic [PhaseBits-1:0] pc, ph, ext, ph_sel;
	logic [39:0]          ext_w;
	logic [24:0]          fs_s, fs_c, xs, xc, u;
	logic [25:0]          w;
	logic                 up, down, stance;
	assign pc     = quo_q + Quarter;
	assign ext_w  = {extra_phase, 24'b0} >> (40 - PhaseBits);
	assign ext    = ext_w[PhaseBits-1:0];
	assign ph     = use_extra ? quo_q + ext : quo_q;
	assign fs_s   = 25'(quo_q[PhaseBits-3:0]) << FracShift;
	assign fs_c   = 25'(pc[PhaseBits-3:0]) << FracShift;
	assign xs     = quo_q[PhaseBits-2] ? ONE_Q24 - fs_s : fs_s;
	assign xc     = pc[PhaseBits-2] ? ONE_Q24 - fs_c : fs_c;
	assign up     = ph <= Quarter;
	assign down   = !up && (ph <= Half);
	assign stance = !up && !down;
	assign ph_sel = up ? ph : ph - Quarter;
	assign u      = 25'(ph_sel) << FracShift;
	assign w      = 26'd50331648 - {u, 1'b0};

	// shared multiplier operand select
	logic [25:0] mul_a, mul_b, coef, acc_nx;
	logic [51:0] prod, prod_rnd;
	logic [27:0] psh;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		coef  = '0;
		unique case (cnt_q) inside
			S_SIN_SQ: begin
				mul_a = {1'b0, xs};
				mul_b = {1'b0, xs};
			end
			S_COS_SQ: begin
				mul_a = {1'b0, xc};
				mul_b = {1'b0, xc};
			end
			S_SIN_C7, S_COS_C7: begin
				mul_a = SC9;
				mul_b = {1'b0, x2_q};
				coef  = SC7;
			end
			S_SIN_C5, S_COS_C5: begin
				mul_a = acc_q;
				mul_b = {1'b0, x2_q};
				coef  = SC5;
			end
			S_SIN_C3, S_COS_C3: begin
				mul_a = acc_q;
				mul_b = {1'b0, x2_q};
				coef  = SC3;
			end
			S_SIN_C1, S_COS_C1: begin
				mul_a = acc_q;
				mul_b = {1'b0, x2_q};
				coef  = SC1;
			end
			S_SIN_END: begin
				mul_a = acc_q;
				mul_b = {1'b0, xs};
			end
			S_COS_END: begin
				mul_a = acc_q;
				mul_b = {1'b0, xc};
			end
			S_HGT_SQ: begin
				mul_a = {1'b0, u};
				mul_b = {1'b0, u};
			end
			S_HGT_EASE: begin
				mul_a = {1'b0, x2_q};
				mul_b = w;
			end
			S_HGT_END: begin
				mul_a = {10'b0, swing_height_um};
				mul_b = acc_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod     = mul_a * mul_b;
	assign psh      = prod[51:24];
	assign acc_nx   = coef - psh[25:0];
	assign prod_rnd = prod + 52'h80_0000;

	// lane state machine and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			mag_q   <= '0;
			neg_q   <= 1'b0;
			per_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			x2_q    <= '0;
			acc_q   <= '0;
			sin_q   <= '0;
			cos_q   <= '0;
			hgt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						mag_q   <= tmag;
						neg_q   <= tsum[41];
						per_q   <= per_eff;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					mag_q <= {mag_q[39:0], 1'b0};
					if (cnt_q == ModLast) begin
						rem_q   <= rem_fix;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						rem_q <= rem_nx;
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_DIV: begin
					rem_q <= rem_dnx;
					quo_q <= {quo_q[PhaseBits-2:0], ge_d};
					if (cnt_q == DivLast) begin
						cnt_q   <= S_SIN_SQ;
						state_q <= ST_POLY;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_POLY: begin
					cnt_q <= cnt_q + 6'd1;
					case (cnt_q) inside
						S_SIN_SQ, S_COS_SQ, S_HGT_SQ: x2_q <= psh[24:0];
						S_SIN_C7, S_SIN_C5, S_SIN_C3, S_SIN_C1,
						S_COS_C7, S_COS_C5, S_COS_C3, S_COS_C1: acc_q <= acc_nx;
						S_SIN_END: sin_q <= q14_finish(psh, quo_q[PhaseBits-1]);
						S_COS_END: cos_q <= q14_finish(psh, pc[PhaseBits-1]);
						S_HGT_EASE: acc_q <= down ? 26'(ONE_Q24) - psh[25:0] : psh[25:0];
						S_HGT_END: begin
							hgt_q   <= stance ? 16'd0 : prod_rnd[39:24];
							state_q <= ST_DONE;
						end
						default: acc_q <= acc_q;
					endcase
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign stat.busy = state_q != ST_IDLE;
	assign stat.done = state_q == ST_DONE;
	assign height    = hgt_q;
	assign cosine    = cos_q;
	assign sine      = sin_q;

endmodule

/* rtl/gpsh_merge.sv */
// Merge stage: waits for all lanes, then loads the response register.
// Depends on gpsh_pkg.
module gpsh_merge import gpsh_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lane_stat_t [NUM_LEGS-1:0]     stat,
	input  logic [NUM_LEGS-1:0][15:0]     lane_height,
	input  logic [NUM_LEGS-1:0][15:0]     lane_cosine,
	input  logic [NUM_LEGS-1:0][15:0]     lane_sine,
	input  logic                          rsp_ready,
	output logic                          take,
	output logic                          rsp_valid,
	output logic [NUM_LEGS-1:0][15:0]     height,
	output logic [NUM_LEGS-1:0][15:0]     cosine,
	output logic [NUM_LEGS-1:0][15:0]     sine
);

	logic                      valid_q;
	logic [NUM_LEGS-1:0][15:0] height_q, cosine_q, sine_q;
	logic [NUM_LEGS-1:0]       done_v;

	always_comb begin
		for (int i = 0; i < NUM_LEGS; i++) begin
			done_v[i] = stat[i].done;
		end
	end

	// load when every lane is done and the slot is free or draining
	assign take = (&done_v) && (!valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (rsp_ready) begin
			valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (take) begin
			height_q <= lane_height;
			cosine_q <= lane_cosine;
			sine_q   <= lane_sine;
		end
	end

	assign rsp_valid = valid_q;
	assign height    = height_q;
	assign cosine    = cosine_q;
	assign sine      = sine_q;

endmodule

/* rtl/gait_phase_and_swing_height_unit.sv */
// Top level of the gait phase and swing height unit: registers, time
// accumulator, four leg lanes and the merge stage. Depends on gpsh_pkg.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    req_type, dt_us, extra phases
//   rsp       out        rsp_valid/rsp_ready    height, cosine, sine per leg
//   apb       in         psel/penable/pready    paddr, pwdata, prdata
//
// Clear and advance transactions give no response.
// A query runs from accept to response valid through the bit-serial remainder
// and division and the shared lane multiplier; req_ready stays low over that
// whole span.
// A pending response stalls the input only once the next query's lanes are done.
// Reset clears time and loads the register defaults.
module gait_phase_and_swing_height_unit import gpsh_pkg::*; #(
	parameter int PhaseBits = PHASE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         req_type,
	input  logic [19:0]        dt_us,
	input  logic               use_extra_offsets,
	input  logic [15:0]        extra_phase_leg0,
	input  logic [15:0]        extra_phase_leg1,
	input  logic [15:0]        extra_phase_leg2,
	input  logic [15:0]        extra_phase_leg3,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [15:0]        height_leg0,
	output logic [15:0]        height_leg1,
	output logic [15:0]        height_leg2,
	output logic [15:0]        height_leg3,
	output logic signed [15:0] cosine_leg0,
	output logic signed [15:0] cosine_leg1,
	output logic signed [15:0] cosine_leg2,
	output logic signed [15:0] cosine_leg3,
	output logic signed [15:0] sine_leg0,
	output logic signed [15:0] sine_leg1,
	output logic signed [15:0] sine_leg2,
	output logic signed [15:0] sine_leg3
);

	logic [PER_W-1:0]             period_q;
	logic [15:0]                  swing_q;
	logic [NUM_LEGS-1:0][23:0]    offset_q;
	logic [TIME_W-1:0]            time_q;
	logic                         use_extra_q;
	logic [NUM_LEGS-1:0][15:0]    extra_q;

	lane_stat_t [NUM_LEGS-1:0]    stat;
	logic [NUM_LEGS-1:0]          busy_v;
	logic [NUM_LEGS-1:0][15:0]    lane_h, lane_c, lane_s, out_h, out_c, out_s;
	logic                         take, req_acc, query;
	logic                         cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST[PER_W-1:0];
			swing_q  <= SWING_RST[15:0];
			offset_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_PERIOD: period_q    <= pwdata[23:0];
				REG_SWING:  swing_q     <= pwdata[15:0];
				REG_OFF0:   offset_q[0] <= pwdata[23:0];
				REG_OFF1:   offset_q[1] <= pwdata[23:0];
				REG_OFF2:   offset_q[2] <= pwdata[23:0];
				REG_OFF3:   offset_q[3] <= pwdata[23:0];
				default:    period_q    <= period_q;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[4:2])
			REG_PERIOD: prdata = {8'b0, period_q};
			REG_SWING:  prdata = {16'b0, swing_q};
			REG_OFF0:   prdata = {8'b0, offset_q[0]};
			REG_OFF1:   prdata = {8'b0, offset_q[1]};
			REG_OFF2:   prdata = {8'b0, offset_q[2]};
			REG_OFF3:   prdata = {8'b0, offset_q[3]};
			default:    prdata = '0;
		endcase
	end

	// request transaction accept
	always_comb begin
		for (int i = 0; i < NUM_LEGS; i++) begin
			busy_v[i] = stat[i].busy;
		end
	end
	assign req_ready = !(|busy_v);
	assign req_acc   = req_valid && req_ready;
	assign query     = req_acc && (req_type == REQ_QUERY);

	// time accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
		end else if (req_acc) begin
			if (req_type == REQ_CLEAR) begin
				time_q <= '0;
			end else if (req_type == REQ_ADVANCE) begin
				time_q <= time_q + TIME_W'(dt_us);
			end
		end
	end

	// query payload held for the lanes
	always_ff @(posedge clk) begin
		if (query) begin
			use_extra_q <= use_extra_offsets;
			extra_q     <= {extra_phase_leg3, extra_phase_leg2,
			                extra_phase_leg1, extra_phase_leg0};
		end
	end

	// leg lanes
	for (genvar g = 0; g < NUM_LEGS; g++) begin : g_lane
		gpsh_lane #(.PhaseBits(PhaseBits)) u_lane (
			.clk             (clk),
			.arst_n          (arst_n),
			.start           (query),
			.take            (take),
			.time_us         (time_q),
			.period_us       (period_q),
			.swing_height_um (swing_q),
			.offset_us       (offset_q[g]),
			.use_extra       (use_extra_q),
			.extra_phase     (extra_q[g]),
			.stat            (stat[g]),
			.height          (lane_h[g]),
			.cosine          (lane_c[g]),
			.sine            (lane_s[g])
		);
	end

	gpsh_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.stat        (stat),
		.lane_height (lane_h),
		.lane_cosine (lane_c),
		.lane_sine   (lane_s),
		.rsp_ready   (rsp_ready),
		.take        (take),
		.rsp_valid   (rsp_valid),
		.height      (out_h),
		.cosine      (out_c),
		.sine        (out_s)
	);

	assign height_leg0 = out_h[0];
	assign height_leg1 = out_h[1];
	assign height_leg2 = out_h[2];
	assign height_leg3 = out_h[3];
	assign cosine_leg0 = out_c[0];
	assign cosine_leg1 = out_c[1];
	assign cosine_leg2 = out_c[2];
	assign cosine_leg3 = out_c[3];
	assign sine_leg0   = out_s[0];
	assign sine_leg1   = out_s[1];
	assign sine_leg2   = out_s[2];
	assign sine_leg3   = out_s[3];

endmodule

/* rtl/gpsh_check.sv */
// Port-level checker for the gait phase and swing height unit, bound to the
// top level. Depends on gpsh_pkg.
module gpsh_check import gpsh_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic [1:0]         req_type,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic signed [15:0] cosine_leg0,
	input logic signed [15:0] sine_leg0
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(cosine_leg0))
		else $error("stalled response changed");

	// a query transaction occupies the lanes
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_type == REQ_QUERY |=> !req_ready)
		else $error("ready after query accept");

	// clear, advance and unused transaction types keep the block ready
	a_ctl_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_type != REQ_QUERY |=> req_ready)
		else $error("ready dropped after non-query");

	// sine stays within one in Q1.14
	a_sine_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> sine_leg0 >= -16'sd16384 && sine_leg0 <= 16'sd16384)
		else $error("sine out of range");

endmodule

bind gait_phase_and_swing_height_unit gpsh_check u_check (.*);

/* tb/tb_top.sv */
// Self-checking testbench for gait_phase_and_swing_height_unit: directed and random
// transactions against an in-bench gait clock predictor. Depends on gpsh_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
	import gpsh_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 800000;

	typedef struct {
		logic [1:0]  kind;
		logic [19:0] dt;
		logic        use_extra;
		logic [15:0] extra [NUM_LEGS];
	} gait_req_t;

	typedef struct {
		logic [15:0] height [NUM_LEGS];
		logic [15:0] cosine [NUM_LEGS];
		logic [15:0] sine [NUM_LEGS];
	} gait_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [1:0] req_type = '0;
	logic [19:0] dt_us = '0;
	logic use_extra_offsets = 1'b0;
	logic [15:0] extra_phase_leg0 = '0, extra_phase_leg1 = '0;
	logic [15:0] extra_phase_leg2 = '0, extra_phase_leg3 = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [15:0] height_leg0, height_leg1, height_leg2, height_leg3;
	logic signed [15:0] cosine_leg0, cosine_leg1, cosine_leg2, cosine_leg3;
	logic signed [15:0] sine_leg0, sine_leg1, sine_leg2, sine_leg3;

	gait_phase_and_swing_height_unit dut (.*);

	always #1 clk = ~clk;

	// predictor state and configuration copy
	logic [39:0] gait_time_us;
	logic [23:0] gait_period;
	logic [15:0] gait_swing;
	logic signed [23:0] gait_offset [NUM_LEGS];

	gait_req_t pending_reqs [$];
	gait_rsp_t expected_rsps [$];
	int errors = 0;
	int n_queries = 0, n_rsps = 0, n_items = 0;
	longint cycles = 0;
	bit quiet = 1'b0;
	bit hold_go = 1'b0;
	int hold_left = 0;
	bit took = 1'b0;

	function automatic longint unsigned quarter_sin(longint unsigned x);
		longint unsigned x2, r;
		x2 = (x * x) >> 24;
		r = 64'd78547 - ((64'd2692 * x2) >> 24);
		r = 64'd1337020 - ((r * x2) >> 24);
		r = 64'd10837479 - ((r * x2) >> 24);
		r = 64'd26353589 - ((r * x2) >> 24);
		r = (r * x) >> 24;
		r = (r + 512) >> 10;
		if (r > 16384) r = 16384;
		return r;
	endfunction

	function automatic logic [15:0] phase_sin(logic [15:0] p);
		longint unsigned x, s;
		x = longint'(p[13:0]) << 10;
		if (p[14]) x = 64'd16777216 - x;
		s = quarter_sin(x);
		return p[15] ? 16'(-s) : 16'(s);
	endfunction

	function automatic longint unsigned smoothstep(longint unsigned u);
		longint unsigned u2;
		u2 = (u * u) >> 24;
		return (u2 * (3 * 64'd16777216 - 2 * u)) >> 24;
	endfunction

	function automatic logic [15:0] foot_lift(logic [15:0] p);
		longint unsigned prof;
		if (p <= 16'd16384) prof = smoothstep(longint'(p) << 10);
		else if (p <= 16'd32768) prof = 64'd16777216 - smoothstep(longint'(p - 16'd16384) << 10);
		else return 16'd0;
		return 16'((longint'(gait_swing) * prof + 64'd8388608) >> 24);
	endfunction

	function automatic logic [15:0] leg_phase(int leg);
		longint per, t, s;
		per = (gait_period == 0) ? 1 : longint'(gait_period);
		t = longint'({24'd0, gait_time_us}) + longint'(gait_offset[leg]);
		s = t % per;
		if (s < 0) s += per;
		return 16'((s << 16) / per);
	endfunction

	// apply one accepted transaction to the predictor
	task automatic predict_gait(input gait_req_t r);
		gait_rsp_t e;
		logic [15:0] p;
		case (r.kind)
			REQ_CLEAR: gait_time_us = '0;
			REQ_ADVANCE: gait_time_us = gait_time_us + r.dt;
			REQ_QUERY: begin
				for (int i = 0; i < NUM_LEGS; i++) begin
					p = leg_phase(i);
					e.height[i] = foot_lift(r.use_extra ? p + r.extra[i] : p);
					e.cosine[i] = phase_sin(p + 16'd16384);
					e.sine[i] = phase_sin(p);
				end
				expected_rsps.push_back(e);
				n_queries++;
			end
			default: ;
		endcase
	endtask

	task automatic report(input string what, input int leg, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		$display("mismatch %s leg %0d: expected %0d got %0d at %0t", what, leg,
			$signed(exp_v), $signed(got_v), $realtime);
		errors++;
	endtask

	// driver: request channel, changes at the falling edge
	always @(negedge clk) begin
		gait_req_t r;
		if (!req_valid || took) begin
			if (arst_n && pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 17)) begin
				r = pending_reqs.pop_front();
				req_type <= r.kind;
				dt_us <= r.dt;
				use_extra_offsets <= r.use_extra;
				extra_phase_leg0 <= r.extra[0];
				extra_phase_leg1 <= r.extra[1];
				extra_phase_leg2 <= r.extra[2];
				extra_phase_leg3 <= r.extra[3];
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver: response ready, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= quiet || ($urandom_range(99) >= 17);
		end
	end

	// monitor: accept transactions and check responses at the rising edge
	always @(posedge clk) begin
		gait_req_t r;
		gait_rsp_t e;
		cycles++;
		took <= req_valid && req_ready;
		if (req_valid && req_ready) begin
			r.kind = req_type;
			r.dt = dt_us;
			r.use_extra = use_extra_offsets;
			r.extra = '{extra_phase_leg0, extra_phase_leg1, extra_phase_leg2, extra_phase_leg3};
			predict_gait(r);
			n_items++;
		end
		if (rsp_valid && rsp_ready) begin
			n_rsps++;
			if (expected_rsps.size() == 0) begin
				$display("unexpected response at %0t", $realtime);
				errors++;
			end else begin
				e = expected_rsps.pop_front();
				foreach (e.height[i]) begin
					logic [15:0] gh, gc, gs;
					gh = (i == 0) ? height_leg0 : (i == 1) ? height_leg1 :
						(i == 2) ? height_leg2 : height_leg3;
					gc = (i == 0) ? cosine_leg0 : (i == 1) ? cosine_leg1 :
						(i == 2) ? cosine_leg2 : cosine_leg3;
					gs = (i == 0) ? sine_leg0 : (i == 1) ? sine_leg1 :
						(i == 2) ? sine_leg2 : sine_leg3;
					if (gh !== e.height[i]) report("height", i, e.height[i], gh);
					if (gc !== e.cosine[i]) report("cosine", i, e.cosine[i], gc);
					if (gs !== e.sine[i]) report("sine", i, e.sine[i], gs);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// register write over apb, mirrored into the predictor
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 5'(idx * 4);
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PERIOD: gait_period = val[23:0];
			REG_SWING: gait_swing = val[15:0];
			default: gait_offset[idx - REG_OFF0] = val[23:0];
		endcase
	endtask

	task automatic add_req(input logic [1:0] kind, input logic [19:0] dt, input logic ux,
			input logic [15:0] e0, input logic [15:0] e1, input logic [15:0] e2,
			input logic [15:0] e3);
		gait_req_t r;
		r.kind = kind;
		r.dt = dt;
		r.use_extra = ux;
		r.extra = '{e0, e1, e2, e3};
		pending_reqs.push_back(r);
	endtask

	task automatic add_random(input int n);
		int k;
		logic [1:0] kind;
		logic [19:0] dt;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			kind = (k < 8) ? REQ_CLEAR : (k < 40) ? REQ_ADVANCE : (k < 94) ? REQ_QUERY : REQ_UNUSED;
			dt = ($urandom_range(9) == 0) ? 20'hFFFFF : 20'($urandom);
			add_req(kind, dt, 1'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom));
		end
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] per, input logic [31:0] sw,
			input logic [31:0] o0, input logic [31:0] o1, input logic [31:0] o2,
			input logic [31:0] o3);
		write_reg(REG_PERIOD, per);
		write_reg(REG_SWING, sw);
		write_reg(REG_OFF0, o0);
		write_reg(REG_OFF1, o1);
		write_reg(REG_OFF2, o2);
		write_reg(REG_OFF3, o3);
	endtask

	initial begin
		gait_time_us = '0;
		gait_period = 24'd500000;
		gait_swing = 16'd50000;
		foreach (gait_offset[i]) gait_offset[i] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: default registers, field extremes, every request kind
		add_req(REQ_QUERY, 20'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
		add_req(REQ_ADVANCE, 20'hFFFFF, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
		add_req(REQ_QUERY, 20'd0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_req(REQ_UNUSED, 20'hFFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_req(REQ_QUERY, 20'd0, 1'b1, 16'h8000, 16'h4000, 16'h0001, 16'h0000);
		add_req(REQ_ADVANCE, 20'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
		add_req(REQ_CLEAR, 20'hFFFFF, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
		add_req(REQ_QUERY, 20'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
		wait_idle();

		// directed: period of one turn so that time maps straight to phase
		set_config(32'd65536, 32'd65535, 32'd0, 32'd16384, 32'd32768, 32'hFFFFFF);
		add_req(REQ_QUERY, 20'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
		add_req(REQ_ADVANCE, 20'd16383, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
		add_req(REQ_QUERY, 20'd0, 1'b1, 16'd1, 16'd2, 16'd16385, 16'd32769);
		add_req(REQ_ADVANCE, 20'd1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
		add_req(REQ_QUERY, 20'd0, 1'b1, 16'd16384, 16'd0, 16'hC000, 16'd8192);
		add_req(REQ_ADVANCE, 20'd8192, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
		add_req(REQ_QUERY, 20'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
		wait_idle();

		// zero period and signed offset extremes
		set_config(32'd0, 32'd0, 32'h800000, 32'h7FFFFF, 32'hFFFFFF, 32'h800000);
		add_req(REQ_QUERY, 20'd0, 1'b1, 16'd5, 16'd6, 16'd7, 16'd8);
		add_random(40);
		wait_idle();

		// random phases across settings, with one quiet stretch and a long stall
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_config(32'hFFFFFF, 32'd65535, 32'h800000, 32'h7FFFFF, 32'd0, 32'h123456);
				1: set_config(32'd1, 32'd12345, 32'd3, 32'h800001, 32'd0, 32'd1);
				2: set_config(32'd500000, 32'd50000, 32'd0, 32'd250000, 32'd125000, 32'd375000);
				default: set_config($urandom_range(1, 24'hFFFFFF), $urandom_range(0, 65535),
					$urandom, $urandom, $urandom, $urandom);
			endcase
			quiet = (ph == 3);
			if (ph == 4) begin
				add_random(60);
				@(posedge clk);
				hold_go = 1'b1;
				add_random(70);
			end else begin
				add_random(130);
			end
			wait_idle();
		end
		quiet = 1'b0;

		$display("%0d transactions accepted, %0d queries predicted, %0d responses checked",
			n_items, n_queries, n_rsps);
		$display("covered default, one-turn, zero, extreme and random register settings");
		if (errors == 0 && expected_rsps.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
